/* rtl/core/bppb_pkg.sv */
// Shared types and constants of the bulk ping-pong buffer manager.
package bppb_pkg;

	localparam int PACKET_BYTES = 64;
	localparam int LEN_W = 7;
	localparam int ACT_W = 3;
	localparam logic [LEN_W-1:0] PKT_LEN = LEN_W'(PACKET_BYTES);

	localparam logic [ACT_W-1:0] ACT_BUS_RESET = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DECONFIG = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CONFIG = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RX_ACQUIRE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TX_ACQUIRE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TX_FLUSH = 3'd5;
	localparam logic [ACT_W-1:0] ACT_IN_DONE = 3'd6;
	localparam logic [ACT_W-1:0] ACT_OUT_DONE = 3'd7;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [LEN_W-1:0] rx_remaining;
		logic [LEN_W-1:0] tx_remaining;
		logic             done_odd;
		logic [LEN_W-1:0] received_count;
	} item_t;

	typedef struct packed {
		logic             arm_valid;
		logic             arm_in;
		logic             arm_odd;
		logic             arm_toggle;
		logic [LEN_W-1:0] arm_length;
		logic             slice_valid;
		logic             slice_odd;
		logic [LEN_W-1:0] slice_length;
		logic             zero_length_needed;
		logic             last;
	} res_t;

	typedef struct packed {
		logic valid;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
		return (v > PKT_LEN) ? PKT_LEN : v;
	endfunction

endpackage

/* rtl/core/bppb_core.sv */
// Endpoint flag state and combinational event evaluation.
module bppb_core import bppb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	output push_t push
);

	typedef logic [5:0] flags_t;

	localparam int F_CPU_DTS = 0;
	localparam int F_CPU_ODD = 1;
	localparam int F_SIE_DTS = 2;
	localparam int F_SIE_ODD = 3;
	localparam int F_BUF0_OWNED = 4;
	localparam int F_BUF1_OWNED = 5;

	flags_t in_q, out_q, in_n, out_n;
	logic [1:0] rx_q, tx_q, rx_n, tx_n;
	logic zlp_q, zlp_n;
	logic [1:0][LEN_W-1:0] cnt_q, cnt_n;
	logic [LEN_W-1:0] tx_rem, fl_len;
	res_t fl_res, r0, r1;
	flags_t fl_flags;
	logic two;

	function automatic flags_t sync_flags(input flags_t f);
		return {2'b00, f[F_SIE_ODD:F_SIE_DTS], f[F_SIE_ODD:F_SIE_DTS]};
	endfunction

	function automatic logic [1:0] pick_slice(input flags_t f);
		logic [1:0] s;
		if (f[F_CPU_ODD] && !f[F_BUF1_OWNED]) begin
			s = 2'b11;
		end else if (!f[F_BUF0_OWNED]) begin
			s = 2'b01;
		end else begin
			s = 2'b00;
		end
		return s;
	endfunction

	function automatic res_t arm_res(input flags_t f, input logic is_in,
			input logic [LEN_W-1:0] len);
		res_t r;
		r = '0;
		r.arm_valid = 1'b1;
		r.arm_in = is_in;
		r.arm_odd = f[F_CPU_ODD];
		r.arm_toggle = f[F_CPU_DTS];
		r.arm_length = len;
		return r;
	endfunction

	function automatic flags_t arm_flags(input flags_t f);
		flags_t g;
		g = f;
		if (f[F_CPU_ODD]) begin
			g[F_BUF1_OWNED] = 1'b1;
		end else begin
			g[F_BUF0_OWNED] = 1'b1;
		end
		g[F_CPU_ODD] = ~f[F_CPU_ODD];
		g[F_CPU_DTS] = ~f[F_CPU_DTS];
		return g;
	endfunction

	function automatic flags_t complete(input flags_t f, input logic odd);
		flags_t g;
		g = f;
		g[F_SIE_ODD] = ~f[F_SIE_ODD];
		g[F_SIE_DTS] = ~f[F_SIE_DTS];
		if (odd) begin
			g[F_BUF1_OWNED] = 1'b0;
		end else begin
			g[F_BUF0_OWNED] = 1'b0;
		end
		return g;
	endfunction

	always_comb begin
		tx_rem = sat_len(item.tx_remaining);
		fl_len = PKT_LEN - tx_rem;
		fl_res = arm_res(in_q, 1'b1, fl_len);
		fl_flags = arm_flags(in_q);
	end

	always_comb begin
		in_n = in_q;
		out_n = out_q;
		rx_n = rx_q;
		tx_n = tx_q;
		zlp_n = zlp_q;
		cnt_n = cnt_q;
		r0 = '0;
		r1 = '0;
		two = 1'b0;
		unique case (item.action)
			ACT_BUS_RESET: begin
				in_n = '0;
				out_n = '0;
				rx_n = '0;
				tx_n = '0;
				zlp_n = 1'b0;
				cnt_n = '0;
			end
			ACT_DECONFIG: begin
				in_n = sync_flags(in_q);
				out_n = sync_flags(out_q);
				rx_n = '0;
				tx_n = '0;
				zlp_n = 1'b0;
			end
			ACT_CONFIG: begin
				in_n = sync_flags(in_q);
				out_n = sync_flags(out_q);
				in_n[F_CPU_DTS] = 1'b0;
				in_n[F_SIE_DTS] = 1'b0;
				out_n[F_CPU_DTS] = 1'b0;
				out_n[F_SIE_DTS] = 1'b0;
				rx_n = '0;
				tx_n = '0;
				zlp_n = 1'b0;
				r0 = arm_res(out_n, 1'b0, PKT_LEN);
				out_n = arm_flags(out_n);
				r1 = arm_res(out_n, 1'b0, PKT_LEN);
				out_n = arm_flags(out_n);
				two = 1'b1;
			end
			ACT_RX_ACQUIRE: begin
				if (!rx_q[0]) begin
					rx_n = pick_slice(out_q);
				end else if (item.rx_remaining == '0) begin
					r0 = arm_res(out_q, 1'b0, PKT_LEN);
					out_n = arm_flags(out_q);
					rx_n = pick_slice(out_n);
				end
				if (rx_n[0]) begin
					r0.slice_valid = 1'b1;
					r0.slice_odd = rx_n[1];
					r0.slice_length = cnt_q[rx_n[1]];
				end
			end
			ACT_TX_ACQUIRE: begin
				if (!tx_q[0]) begin
					tx_n = pick_slice(in_q);
					r0.slice_length = PKT_LEN;
				end else if (item.tx_remaining == '0) begin
					r0 = fl_res;
					in_n = fl_flags;
					zlp_n = (fl_len == PKT_LEN);
					tx_n = pick_slice(fl_flags);
					r0.slice_length = PKT_LEN;
				end else begin
					r0.slice_length = tx_rem;
				end
				if (tx_n[0]) begin
					r0.slice_valid = 1'b1;
					r0.slice_odd = tx_n[1];
				end else begin
					r0.slice_length = '0;
				end
			end
			ACT_TX_FLUSH: begin
				if (tx_q[0]) begin
					r0 = fl_res;
					in_n = fl_flags;
					zlp_n = (fl_len == PKT_LEN);
					tx_n = pick_slice(fl_flags);
					if (tx_n[0]) begin
						r0.slice_valid = 1'b1;
						r0.slice_odd = tx_n[1];
						r0.slice_length = PKT_LEN;
					end
				end
			end
			ACT_IN_DONE: begin
				in_n = complete(in_q, item.done_odd);
			end
			ACT_OUT_DONE: begin
				out_n = complete(out_q, item.done_odd);
				cnt_n[item.done_odd] = sat_len(item.received_count);
			end
			default: begin
				in_n = in_q;
			end
		endcase
		r0.zero_length_needed = zlp_n;
		r1.zero_length_needed = zlp_n;
		r0.last = ~two;
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q <= '0;
			out_q <= '0;
			rx_q <= '0;
			tx_q <= '0;
			zlp_q <= 1'b0;
		end else if (fire) begin
			in_q <= in_n;
			out_q <= out_n;
			rx_q <= rx_n;
			tx_q <= tx_n;
			zlp_q <= zlp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cnt_q <= cnt_n;
		end
	end

	assign push.valid = fire;
	assign push.two = two;
	assign push.r0 = r0;
	assign push.r1 = r1;

`ifndef ASSERT_OFF
	a_rx_odd_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rx_q[1] |-> rx_q[0]) else $error("Receive slice marked odd without being held.");
	a_tx_odd_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tx_q[1] |-> tx_q[0]) else $error("Transmit slice marked odd without being held.");
	a_bus_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == ACT_BUS_RESET |=> in_q == '0 && out_q == '0 && !zlp_q)
		else $error("Bus reset left endpoint flags set.");
`endif

endmodule

/* rtl/core/bppb_outq.sv */
// Two-entry result queue that decouples evaluation from the result channel.
module bppb_outq import bppb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [1:0] room,
	output res_t       head
);

	res_t ent_q [2];
	res_t e0, e1;
	logic [1:0] cnt_q, cnt_n;
	logic pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign room = 2'd2 - cnt_q + {1'b0, pop};
	assign head = ent_q[0];

	always_comb begin
		e0 = ent_q[0];
		e1 = ent_q[1];
		cnt_n = cnt_q;
		if (pop) begin
			e0 = ent_q[1];
			cnt_n = cnt_q - 2'd1;
		end
		if (push.valid) begin
			if (cnt_n == 2'd0) begin
				e0 = push.r0;
				e1 = push.r1;
			end else begin
				e1 = push.r0;
			end
			cnt_n = cnt_n + (push.two ? 2'd2 : 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= e0;
		ent_q[1] <= e1;
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("Result queue count out of range.");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> room >= (push.two ? 2'd2 : 2'd1))
		else $error("Result queue overflow.");
	a_pair_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.two |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))
		else $error("Result pair pushed into occupied queue.");
`endif

endmodule

/* rtl/core/bulk_ping_pong_buffer_manager.sv */
// Top level of the bulk IN/OUT ping-pong buffer manager.
//
//   channel   handshake            payload
//   input     in_valid/in_stall    action, rx_remaining, tx_remaining, done_odd,
//                                  received_count
//   result    out_valid/out_stall  arm_*, slice_*, zero_length_needed, last
//
// Each event is registered, and that register holds it while the result queue lacks room;
// it is evaluated from that register and its results wait in the result queue to transfer.
// One event is taken every cycle while results drain; a configure event yields two
// results and needs both entries of the result queue.
// A stalled result channel backs up into in_stall once the queue lacks room for an event's results.
// Reset clears all flags and slices; received byte counts hold garbage until
// a bus reset or an OUT completion writes them.
module bulk_ping_pong_buffer_manager import bppb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ACT_W-1:0] action,
	input  logic [LEN_W-1:0] rx_remaining,
	input  logic [LEN_W-1:0] tx_remaining,
	input  logic             done_odd,
	input  logic [LEN_W-1:0] received_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             arm_valid,
	output logic             arm_in,
	output logic             arm_odd,
	output logic             arm_toggle,
	output logic [LEN_W-1:0] arm_length,
	output logic             slice_valid,
	output logic             slice_odd,
	output logic [LEN_W-1:0] slice_length,
	output logic             zero_length_needed,
	output logic             last
);

	logic valid_s1;
	item_t item_s1;
	logic fire;
	logic [1:0] room;
	logic [1:0] need;
	push_t push;
	res_t head;

	assign need = (item_s1.action == ACT_CONFIG) ? 2'd2 : 2'd1;
	assign fire = valid_s1 && (room >= need);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action <= action;
			item_s1.rx_remaining <= rx_remaining;
			item_s1.tx_remaining <= tx_remaining;
			item_s1.done_odd <= done_odd;
			item_s1.received_count <= received_count;
		end
	end

	bppb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.push   (push)
	);

	bppb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.room      (room),
		.head      (head)
	);

	assign arm_valid = head.arm_valid;
	assign arm_in = head.arm_in;
	assign arm_odd = head.arm_odd;
	assign arm_toggle = head.arm_toggle;
	assign arm_length = head.arm_length;
	assign slice_valid = head.slice_valid;
	assign slice_odd = head.slice_odd;
	assign slice_length = head.slice_length;
	assign zero_length_needed = head.zero_length_needed;
	assign last = head.last;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the bulk ping-pong buffer manager with directed and random events.
module tb_top;
	import bppb_pkg::*;

	localparam int CPU_DTS = 0;
	localparam int CPU_ODD = 1;
	localparam int SIE_DTS = 2;
	localparam int SIE_ODD = 3;
	localparam int BUF0_OWNED = 4;
	localparam int BUF1_OWNED = 5;
	localparam int RANDOM_ITEMS = 1500;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ACT_W-1:0] action = ACT_BUS_RESET;
	logic [LEN_W-1:0] rx_remaining = '0;
	logic [LEN_W-1:0] tx_remaining = '0;
	logic done_odd = 1'b0;
	logic [LEN_W-1:0] received_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic arm_valid;
	logic arm_in;
	logic arm_odd;
	logic arm_toggle;
	logic [LEN_W-1:0] arm_length;
	logic slice_valid;
	logic slice_odd;
	logic [LEN_W-1:0] slice_length;
	logic zero_length_needed;
	logic last;

	logic [5:0] in_fl = '0;
	logic [5:0] out_fl = '0;
	logic [1:0] rx_held = '0;
	logic [1:0] tx_held = '0;
	logic zlp = 1'b0;
	logic [LEN_W-1:0] rx_count [2];
	res_t awaited_results [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int stall_hold = 0;
	bit idling_on = 1'b1;

	bulk_ping_pong_buffer_manager i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.rx_remaining(rx_remaining),
		.tx_remaining(tx_remaining),
		.done_odd(done_odd),
		.received_count(received_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.arm_valid(arm_valid),
		.arm_in(arm_in),
		.arm_odd(arm_odd),
		.arm_toggle(arm_toggle),
		.arm_length(arm_length),
		.slice_valid(slice_valid),
		.slice_odd(slice_odd),
		.slice_length(slice_length),
		.zero_length_needed(zero_length_needed),
		.last(last)
	);

	always #5ns clk = ~clk;

	function automatic logic [LEN_W-1:0] clip_to_packet(input logic [LEN_W-1:0] v);
		return (v > PKT_LEN) ? PKT_LEN : v;
	endfunction

	function automatic logic [1:0] choose_buffer(input logic [5:0] f);
		if (f[CPU_ODD] && !f[BUF1_OWNED])
			return 2'b11;
		if (!f[BUF0_OWNED])
			return 2'b01;
		return 2'b00;
	endfunction

	task automatic drop_pipes();
		in_fl = {2'b00, in_fl[SIE_ODD], in_fl[SIE_DTS], in_fl[SIE_ODD], in_fl[SIE_DTS]};
		out_fl = {2'b00, out_fl[SIE_ODD], out_fl[SIE_DTS], out_fl[SIE_ODD], out_fl[SIE_DTS]};
		rx_held = '0;
		tx_held = '0;
		zlp = 1'b0;
	endtask

	task automatic arm_next(inout logic [5:0] f, input logic is_in, input logic [LEN_W-1:0] len,
			inout res_t r);
		r.arm_valid = 1'b1;
		r.arm_in = is_in;
		r.arm_odd = f[CPU_ODD];
		r.arm_toggle = f[CPU_DTS];
		r.arm_length = len;
		if (f[CPU_ODD]) begin
			f[BUF1_OWNED] = 1'b1;
		end else begin
			f[BUF0_OWNED] = 1'b1;
		end
		f[CPU_ODD] = ~f[CPU_ODD];
		f[CPU_DTS] = ~f[CPU_DTS];
	endtask

	task automatic report_tx(inout res_t r, input logic [LEN_W-1:0] len);
		if (tx_held[0]) begin
			r.slice_valid = 1'b1;
			r.slice_odd = tx_held[1];
			r.slice_length = len;
		end
	endtask

	task automatic flush_tx(input logic [LEN_W-1:0] rem, inout res_t r);
		logic [LEN_W-1:0] len;
		len = PKT_LEN - clip_to_packet(rem);
		arm_next(in_fl, 1'b1, len, r);
		zlp = (len == PKT_LEN);
		tx_held = choose_buffer(in_fl);
		report_tx(r, PKT_LEN);
	endtask

	task automatic finish_buffer(inout logic [5:0] f, input logic odd);
		f[SIE_DTS] = ~f[SIE_DTS];
		f[SIE_ODD] = ~f[SIE_ODD];
		if (odd) begin
			f[BUF1_OWNED] = 1'b0;
		end else begin
			f[BUF0_OWNED] = 1'b0;
		end
	endtask

	task automatic step_buffer_state(input item_t it);
		res_t r0;
		res_t r1;
		bit two;
		r0 = '0;
		r1 = '0;
		two = 1'b0;
		case (it.action)
			ACT_BUS_RESET: begin
				in_fl = '0;
				out_fl = '0;
				drop_pipes();
				rx_count[0] = '0;
				rx_count[1] = '0;
			end
			ACT_DECONFIG: begin
				drop_pipes();
			end
			ACT_CONFIG: begin
				drop_pipes();
				in_fl[CPU_DTS] = 1'b0;
				in_fl[SIE_DTS] = 1'b0;
				out_fl[CPU_DTS] = 1'b0;
				out_fl[SIE_DTS] = 1'b0;
				arm_next(out_fl, 1'b0, PKT_LEN, r0);
				arm_next(out_fl, 1'b0, PKT_LEN, r1);
				two = 1'b1;
			end
			ACT_RX_ACQUIRE: begin
				if (!rx_held[0]) begin
					rx_held = choose_buffer(out_fl);
				end else if (it.rx_remaining == '0) begin
					arm_next(out_fl, 1'b0, PKT_LEN, r0);
					rx_held = choose_buffer(out_fl);
				end
				if (rx_held[0]) begin
					r0.slice_valid = 1'b1;
					r0.slice_odd = rx_held[1];
					r0.slice_length = rx_count[rx_held[1]];
				end
			end
			ACT_TX_ACQUIRE: begin
				if (!tx_held[0]) begin
					tx_held = choose_buffer(in_fl);
					report_tx(r0, PKT_LEN);
				end else if (it.tx_remaining == '0) begin
					flush_tx(it.tx_remaining, r0);
				end else begin
					report_tx(r0, clip_to_packet(it.tx_remaining));
				end
			end
			ACT_TX_FLUSH: begin
				if (tx_held[0])
					flush_tx(it.tx_remaining, r0);
			end
			ACT_IN_DONE: begin
				finish_buffer(in_fl, it.done_odd);
			end
			ACT_OUT_DONE: begin
				finish_buffer(out_fl, it.done_odd);
				rx_count[it.done_odd] = clip_to_packet(it.received_count);
			end
			default: ;
		endcase
		r0.zero_length_needed = zlp;
		r1.zero_length_needed = zlp;
		r0.last = !two;
		r1.last = 1'b1;
		awaited_results.push_back(r0);
		if (two)
			awaited_results.push_back(r1);
	endtask

	function automatic int pick_gap();
		int r;
		if (!idling_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [LEN_W-1:0] pick_remaining(input int zero_pct);
		int r;
		if ($urandom_range(0, 99) < zero_pct)
			return '0;
		r = $urandom_range(0, 99);
		if (r < 15)
			return PKT_LEN;
		if (r < 30)
			return LEN_W'($urandom_range(PACKET_BYTES + 1, 127));
		return LEN_W'($urandom_range(1, PACKET_BYTES - 1));
	endfunction

	function automatic logic [LEN_W-1:0] pick_count();
		if ($urandom_range(0, 99) < 80)
			return LEN_W'($urandom_range(0, PACKET_BYTES));
		return LEN_W'($urandom_range(PACKET_BYTES + 1, 127));
	endfunction

	function automatic string describe_result(input res_t r);
		return $sformatf({"arm %0d in %0d odd %0d tgl %0d len %0d | ",
			"slice %0d odd %0d len %0d | zlp %0d last %0d"},
			r.arm_valid, r.arm_in, r.arm_odd, r.arm_toggle, r.arm_length, r.slice_valid,
			r.slice_odd, r.slice_length, r.zero_length_needed, r.last);
	endfunction

	task automatic send_event(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] rx_rem,
			input logic [LEN_W-1:0] tx_rem, input logic odd, input logic [LEN_W-1:0] count);
		int gap;
		item_t it;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		rx_remaining = rx_rem;
		tx_remaining = tx_rem;
		done_odd = odd;
		received_count = count;
		do @(posedge clk); while (in_stall);
		it = '0;
		it.action = act;
		it.rx_remaining = rx_rem;
		it.tx_remaining = tx_rem;
		it.done_odd = odd;
		it.received_count = count;
		step_buffer_state(it);
	endtask

	// The run opens with a bus reset so that both received counts are defined before any
	// receive slice is taken; arst_n is never asserted again afterwards.
	task automatic test_bus_reset_and_configure();
		send_event(ACT_BUS_RESET, 7'h7F, 7'h7F, 1'b1, 7'h7F);
		send_event(ACT_RX_ACQUIRE, '0, '0, 1'b0, '0);
		send_event(ACT_CONFIG, 7'h7F, '0, 1'b0, 7'h7F);
	endtask

	task automatic test_receive_path();
		send_event(ACT_RX_ACQUIRE, '0, '0, 1'b0, '0);
		send_event(ACT_OUT_DONE, '0, '0, 1'b0, 7'h7F);
		send_event(ACT_OUT_DONE, '0, '0, 1'b1, '0);
		send_event(ACT_RX_ACQUIRE, 7'd9, '0, 1'b0, '0);
		send_event(ACT_RX_ACQUIRE, 7'h7F, '0, 1'b0, '0);
		send_event(ACT_RX_ACQUIRE, '0, '0, 1'b0, '0);
		send_event(ACT_RX_ACQUIRE, '0, '0, 1'b0, '0);
	endtask

	task automatic test_transmit_path();
		send_event(ACT_TX_ACQUIRE, '0, 7'd5, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, 7'd10, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, 7'd100, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, '0, 1'b0, '0);
		send_event(ACT_TX_FLUSH, '0, 7'h7F, 1'b0, '0);
		send_event(ACT_TX_FLUSH, '0, 7'd3, 1'b0, '0);
		send_event(ACT_IN_DONE, '0, '0, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, 7'd1, 1'b0, '0);
		send_event(ACT_TX_FLUSH, '0, PKT_LEN, 1'b0, '0);
		send_event(ACT_IN_DONE, '0, '0, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, 7'd20, 1'b0, '0);
		send_event(ACT_TX_ACQUIRE, '0, '0, 1'b0, '0);
	endtask

	task automatic test_deconfigure();
		send_event(ACT_DECONFIG, 7'h7F, 7'h7F, 1'b1, 7'h7F);
		send_event(ACT_TX_FLUSH, '0, '0, 1'b0, '0);
		send_event(ACT_OUT_DONE, '0, '0, 1'b1, PKT_LEN);
	endtask

	// Completions mostly follow the controller pointer as a real bus would, with some
	// out-of-order ones mixed in.
	task automatic test_random_traffic();
		int n;
		int r;
		logic [ACT_W-1:0] act;
		logic odd;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			idling_on = ((n / 100) % 4) != 3;
			r = $urandom_range(0, 99);
			if (r < 2)
				act = ACT_BUS_RESET;
			else if (r < 5)
				act = ACT_DECONFIG;
			else if (r < 10)
				act = ACT_CONFIG;
			else if (r < 35)
				act = ACT_RX_ACQUIRE;
			else if (r < 55)
				act = ACT_TX_ACQUIRE;
			else if (r < 68)
				act = ACT_TX_FLUSH;
			else if (r < 84)
				act = ACT_IN_DONE;
			else
				act = ACT_OUT_DONE;
			if ($urandom_range(0, 99) < 85)
				odd = (act == ACT_IN_DONE) ? in_fl[SIE_ODD] : out_fl[SIE_ODD];
			else
				odd = 1'($urandom_range(0, 1));
			send_event(act, pick_remaining(50), pick_remaining(30), odd, pick_count());
		end
		idling_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold = stall_hold - 1;
		end else if (out_stall || !idling_on) begin
			out_stall = 1'b0;
			stall_hold = idling_on ? $urandom_range(0, 8) : 0;
		end else begin
			out_stall = 1'b1;
			stall_hold = ($urandom_range(0, 9) == 0) ?
				$urandom_range(10, 30) : $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '0;
			got.arm_valid = arm_valid;
			got.arm_in = arm_in;
			got.arm_odd = arm_odd;
			got.arm_toggle = arm_toggle;
			got.arm_length = arm_length;
			got.slice_valid = slice_valid;
			got.slice_odd = slice_odd;
			got.slice_length = slice_length;
			got.zero_length_needed = zero_length_needed;
			got.last = last;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected result transfer: %s", describe_result(got));
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("Result mismatch at %0t", $realtime);
						$display("  expected: %s", describe_result(want));
						$display("  actual:   %s", describe_result(got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_bus_reset_and_configure();
		test_receive_path();
		test_transmit_path();
		test_deconfigure();
		test_random_traffic();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
